/* src/divider_timer_with_overflow_reload_top_macros.svh */
// Assertion macros shared by the timer modules.
// They expect signals named clk and arst_n in the module that uses them.
`ifndef DIVIDER_TIMER_WITH_OVERFLOW_RELOAD_TOP_MACROS_SVH
`define DIVIDER_TIMER_WITH_OVERFLOW_RELOAD_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dtt_pkg.sv */
`default_nettype none

package dtt_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		REG_DIV  = 3'd0,
		REG_TIMA = 3'd1,
		REG_TMA  = 3'd2,
		REG_TAC  = 3'd3,
		REG_IF   = 3'd4
	} reg_index_t;

	localparam logic [7:0] IF_RESET      = 8'hE1;
	localparam logic [7:0] IF_TIMER      = 8'h04;
	localparam logic [7:0] TAC_READ_FILL = 8'hF8;
	localparam logic [7:0] UNMAPPED_READ = 8'hFF;

	typedef struct packed {
		req_type_t  req;
		reg_index_t idx;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] irq_flags;
	} result_t;

	// Gated counter tap: the selected counter bit ANDed with the enable bit.
	function automatic logic tap_bit(input logic [15:0] cnt, input logic [2:0] tac);
		logic sel;
		unique case (tac[1:0])
			2'd0: sel = cnt[7];
			2'd1: sel = cnt[1];
			2'd2: sel = cnt[3];
			default: sel = cnt[5];
		endcase
		return sel & tac[2];
	endfunction

endpackage

`default_nettype wire

/* src/dtt_core.sv */
`default_nettype none
`include "divider_timer_with_overflow_reload_top_macros.svh"

module dtt_core
	import dtt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step_en,
	input  wire item_t   item,
	output result_t      res
);

	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  tima_q, tima_d;
	logic [7:0]  tma_q, tma_d;
	logic [2:0]  tac_q, tac_d;
	logic [7:0]  ifl_q, ifl_d;
	logic        last_tap_q, last_tap_d;
	logic        reload_pend_q, reload_pend_d;
	logic        reload_now_q, reload_now_d;
	logic        tap;
	logic [7:0]  rd;

	always_comb begin
		cnt_d         = cnt_q;
		tima_d        = tima_q;
		tma_d         = tma_q;
		tac_d         = tac_q;
		ifl_d         = ifl_q;
		last_tap_d    = last_tap_q;
		reload_pend_d = reload_pend_q;
		reload_now_d  = reload_now_q;
		rd            = '0;

		unique case (item.req)
			REQ_READ: begin
				unique case (item.idx)
					REG_DIV:  rd = cnt_q[13:6];
					REG_TIMA: rd = tima_q;
					REG_TMA:  rd = tma_q;
					REG_TAC:  rd = TAC_READ_FILL | {5'd0, tac_q};
					REG_IF:   rd = ifl_q;
					default:  rd = UNMAPPED_READ;
				endcase
			end
			REQ_WRITE: begin
				unique case (item.idx)
					REG_DIV: begin
						cnt_d = '0;
						if (last_tap_d) begin
							tima_d = tima_d + 8'd1;
							if (tima_d == 8'd0) begin
								reload_pend_d = 1'b1;
							end
						end
						last_tap_d = 1'b0;
					end
					REG_TIMA: begin
						if (!reload_now_q) begin
							tima_d = item.data;
						end
						reload_pend_d = 1'b0;
					end
					REG_TMA: begin
						if (reload_now_q) begin
							tima_d = item.data;
						end
						tma_d = item.data;
					end
					REG_TAC: begin
						if (last_tap_d && !item.data[2]) begin
							tima_d = tima_d + 8'd1;
							if (tima_d == 8'd0) begin
								reload_pend_d = 1'b1;
							end
						end
						last_tap_d = last_tap_d & item.data[2];
						tac_d      = item.data[2:0];
					end
					REG_IF: ifl_d = item.data;
					default: ;
				endcase
			end
			default: ;
		endcase

		// Machine-cycle tick: finish a pending reload, then advance the counter.
		reload_now_d = 1'b0;
		if (reload_pend_d) begin
			reload_pend_d = 1'b0;
			ifl_d         = ifl_d | IF_TIMER;
			tima_d        = tma_d;
			reload_now_d  = 1'b1;
		end
		cnt_d = cnt_d + 16'd1;
		tap   = tap_bit(cnt_d, tac_d);
		if (last_tap_d && !tap) begin
			tima_d = tima_d + 8'd1;
			if (tima_d == 8'd0) begin
				reload_pend_d = 1'b1;
			end
		end
		last_tap_d = tap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			tima_q        <= '0;
			tma_q         <= '0;
			tac_q         <= '0;
			ifl_q         <= IF_RESET;
			last_tap_q    <= 1'b0;
			reload_pend_q <= 1'b0;
			reload_now_q  <= 1'b0;
		end else if (step_en) begin
			cnt_q         <= cnt_d;
			tima_q        <= tima_d;
			tma_q         <= tma_d;
			tac_q         <= tac_d;
			ifl_q         <= ifl_d;
			last_tap_q    <= last_tap_d;
			reload_pend_q <= reload_pend_d;
			reload_now_q  <= reload_now_d;
		end
	end

	assign res.read_data = rd;
	assign res.irq_flags = ifl_d;

	`DTT_ASSERT_NEXT(a_state_holds, !step_en, $stable(cnt_q) && $stable(tima_q) && $stable(ifl_q),
		"Timer state changed without a transaction.")
	`DTT_ASSERT_NEXT(a_counter_steps,
		step_en && !(item.req == REQ_WRITE && item.idx == REG_DIV),
		cnt_q == $past(cnt_q) + 16'd1,
		"Cycle counter did not advance by one.")
	`DTT_ASSERT_NEXT(a_reload_done,
		step_en && reload_pend_q && !(item.req == REQ_WRITE && item.idx == REG_TIMA),
		reload_now_q && ifl_q[2],
		"Pending reload was not carried out with the timer interrupt.")

endmodule

`default_nettype wire

/* src/divider_timer_with_overflow_reload_top.sv */
// A transaction is held in the input stage until it advances into the result register.
// Throughput: one transaction per cycle while the result register is free or drained by out_ready.
// The input stage accepts a new transaction whenever the result register is free or drained.
// Reset is asynchronous and active low and takes effect at once.
// After reset the counters and timer registers are zero and the interrupt flags read 0xE1.
`default_nettype none
`include "divider_timer_with_overflow_reload_top_macros.svh"

module divider_timer_with_overflow_reload_top
	import dtt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] req_type,
	input  wire logic [2:0] reg_index,
	input  wire logic [7:0] write_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data,
	output logic [7:0]      irq_flags
);

	logic    valid_s1;
	item_t   item_s1;
	logic    adv;
	result_t res;
	logic    out_valid_q;
	result_t res_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.req  <= req_type_t'(req_type);
			item_s1.idx  <= reg_index_t'(reg_index);
			item_s1.data <= write_data;
		end
	end

	dtt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = res_q.read_data;
	assign irq_flags = res_q.irq_flags;

	`DTT_ASSERT_NEXT(a_stage_holds, valid_s1 && !adv, valid_s1,
		"Input stage dropped a transaction that had not advanced.")
	`DTT_ASSERT_NEXT(a_result_follows, adv, out_valid,
		"Advanced transaction did not produce a result.")
	`DTT_ASSERT_NOW(a_no_overwrite, adv, !out_valid || out_ready,
		"Result register overwritten before it was taken.")

endmodule

`default_nettype wire

/* bench/divider_timer_with_overflow_reload_top_tb.sv */
module divider_timer_with_overflow_reload_top_tb;
	import dtt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int CALM_TAIL = 80;
	localparam int RANDOM_TARGET = 625;
	localparam logic [1:0] REQ_RSVD = 2'd3;
	localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;
	localparam logic [1:0] TAC_SEL_FAST = 2'd1;

	typedef struct packed {
		logic [1:0] req;
		logic [2:0] idx;
		logic [7:0] data;
	} timer_txn_t;

	typedef struct packed {
		logic [7:0] rd;
		logic [7:0] fl;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [2:0] reg_index = '0;
	logic [7:0] write_data = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [7:0] read_data;
	logic [7:0] irq_flags;

	divider_timer_with_overflow_reload_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.reg_index(reg_index),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.irq_flags(irq_flags)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	timer_txn_t txn_queue[$];
	timer_result_t predicted_results[$];
	timer_txn_t cur_txn;
	timer_result_t got_result;
	timer_result_t want;
	logic in_taken = 1'b0;
	int txn_total = 0;
	int accepted_cnt = 0;
	int in_gap = 0;
	int out_gap = 0;
	int idle_cycles = 0;
	int failures = 0;

	logic [15:0] div_cnt = '0;
	logic [7:0] tima = '0;
	logic [7:0] tma = '0;
	logic [2:0] tac = '0;
	logic [7:0] if_reg = IF_RESET;
	logic tap_prev = 1'b0;
	logic reload_due = 1'b0;
	logic reload_done = 1'b0;

	function automatic logic tap_of(input logic [15:0] c, input logic [2:0] ctl);
		logic b;
		case (ctl[1:0])
			2'd0: b = c[7];
			2'd1: b = c[1];
			2'd2: b = c[3];
			default: b = c[5];
		endcase
		return b & ctl[2];
	endfunction

	task automatic bump_on_fall(input logic was, input logic now);
		if (was && !now) begin
			tima = tima + 8'd1;
			if (tima == 8'd0)
				reload_due = 1'b1;
		end
	endtask

	task automatic set_div(input logic [15:0] v);
		logic t;
		div_cnt = v;
		t = tap_of(div_cnt, tac);
		bump_on_fall(tap_prev, t);
		tap_prev = t;
	endtask

	task automatic advance_timer(input logic [1:0] rq, input logic [2:0] ix,
			input logic [7:0] wd, output timer_result_t res);
		logic old;
		res.rd = 8'h00;
		if (rq == REQ_READ) begin
			case (ix)
				REG_DIV: res.rd = div_cnt[13:6];
				REG_TIMA: res.rd = tima;
				REG_TMA: res.rd = tma;
				REG_TAC: res.rd = TAC_READ_FILL | {5'd0, tac};
				REG_IF: res.rd = if_reg;
				default: res.rd = UNMAPPED_READ;
			endcase
		end else if (rq == REQ_WRITE) begin
			case (ix)
				REG_DIV: set_div(16'd0);
				REG_TIMA: begin
					if (!reload_done)
						tima = wd;
					reload_due = 1'b0;
				end
				REG_TMA: begin
					if (reload_done)
						tima = wd;
					tma = wd;
				end
				REG_TAC: begin
					old = tap_prev;
					tap_prev = tap_prev & wd[2];
					bump_on_fall(old, tap_prev);
					tac = wd[2:0];
				end
				REG_IF: if_reg = wd;
				default: ;
			endcase
		end
		reload_done = 1'b0;
		if (reload_due) begin
			reload_due = 1'b0;
			if_reg = if_reg | IF_TIMER;
			tima = tma;
			reload_done = 1'b1;
		end
		set_div(div_cnt + 16'd1);
		res.fl = if_reg;
	endtask

	function automatic void queue_txn(input logic [1:0] r, input logic [2:0] i,
			input logic [7:0] d);
		txn_queue.push_back('{req: r, idx: i, data: d});
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap = in_gap - 1;
					in_valid <= 1'b0;
				end else if (txn_queue.size() > 0 && accepted_cnt < txn_total - CALM_TAIL
						&& $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (txn_queue.size() > 0) begin
					cur_txn = txn_queue.pop_front();
					req_type <= cur_txn.req;
					reg_index <= cur_txn.idx;
					write_data <= cur_txn.data;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap = out_gap - 1;
				out_ready <= 1'b0;
			end else if (accepted_cnt < txn_total - CALM_TAIL && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				advance_timer(req_type, reg_index, write_data, got_result);
				predicted_results.push_back(got_result);
				accepted_cnt = accepted_cnt + 1;
			end
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual read_data %02h irq_flags %02h",
						$time, read_data, irq_flags);
					failures = failures + 1;
				end else begin
					want = predicted_results.pop_front();
					if (read_data !== want.rd) begin
						$display("%0t: read_data mismatch, expected %02h, actual %02h",
							$time, want.rd, read_data);
						failures = failures + 1;
					end
					if (irq_flags !== want.fl) begin
						$display("%0t: irq_flags mismatch, expected %02h, actual %02h",
							$time, want.fl, irq_flags);
						failures = failures + 1;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int steps;
		int pick;
		logic [7:0] d;
		logic [2:0] ix;

		queue_txn(REQ_READ, REG_DIV, 8'h00);
		queue_txn(REQ_READ, REG_TIMA, 8'h00);
		queue_txn(REQ_READ, REG_TMA, 8'h00);
		queue_txn(REQ_READ, REG_TAC, 8'h00);
		queue_txn(REQ_READ, REG_IF, 8'h00);
		queue_txn(REQ_READ, REG_UNMAPPED_HI, 8'h00);
		queue_txn(REQ_RSVD, REG_DIV, 8'hFF);
		queue_txn(REQ_WRITE, REG_IF, 8'h00);
		queue_txn(REQ_WRITE, REG_TMA, 8'hFF);
		queue_txn(REQ_WRITE, REG_TIMA, 8'hFF);
		queue_txn(REQ_WRITE, REG_TAC, 8'h05);
		repeat (5) queue_txn(REQ_TICK, REG_DIV, 8'h00);
		queue_txn(REQ_READ, REG_TIMA, 8'h00);
		queue_txn(REQ_WRITE, REG_TIMA, 8'h00);
		queue_txn(REQ_WRITE, REG_DIV, 8'hFF);
		queue_txn(REQ_WRITE, REG_TAC, 8'h00);
		queue_txn(REQ_WRITE, REG_UNMAPPED_LO, 8'hAA);
		queue_txn(REQ_WRITE, REG_IF, 8'hFF);
		queue_txn(REQ_READ, REG_IF, 8'h00);
		queue_txn(REQ_WRITE, REG_TAC, 8'hFA);
		queue_txn(REQ_READ, REG_TAC, 8'h00);

		// Most of the random part arms the timer near overflow and then mixes
		// ticks with register accesses, so reloads collide with writes.
		while (txn_queue.size() < RANDOM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				steps = $urandom_range(1, 8);
				repeat (steps)
					queue_txn(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)));
			end else begin
				d = 8'($urandom_range(0, 255));
				d[2] = ($urandom_range(0, 7) != 0);
				if ($urandom_range(0, 3) != 0)
					d[1:0] = TAC_SEL_FAST;
				queue_txn(REQ_WRITE, REG_TAC, d);
				d = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'hF0, 8'hFF))
					: 8'($urandom_range(0, 255));
				queue_txn(REQ_WRITE, REG_TMA, d);
				queue_txn(REQ_WRITE, REG_TIMA, 8'($urandom_range(8'hFA, 8'hFF)));
				steps = $urandom_range(8, 30);
				repeat (steps) begin
					pick = $urandom_range(0, 9);
					if (pick < 5) begin
						queue_txn(REQ_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
					end else if (pick < 7) begin
						ix = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
							: 3'($urandom_range(0, 4));
						queue_txn(REQ_READ, ix, 8'($urandom_range(0, 255)));
					end else begin
						ix = 3'($urandom_range(0, 4));
						d = 8'($urandom_range(0, 255));
						if (ix == REG_TIMA && $urandom_range(0, 3) != 0)
							d = 8'($urandom_range(8'hF8, 8'hFF));
						queue_txn(REQ_WRITE, ix, d);
					end
				end
			end
		end
		txn_total = txn_queue.size();

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		while (txn_queue.size() != 0 || in_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
